[rtl/core/pta_pkg.sv]
// shared types, constants and decode functions for the product topology adjacency unit
`default_nettype none

package pta_pkg;

  localparam int unsigned NumDims    = 5;
  localparam int unsigned MaxDims    = 5;
  localparam int unsigned MaxDimSize = 16;
  localparam int unsigned NodeW      = 20;
  localparam int unsigned CoordW     = 4;
  localparam int unsigned SizeW      = 5;
  localparam int unsigned CountW     = 3;
  localparam int unsigned ShiftW     = 5;
  localparam int unsigned ThreeW     = 3;
  localparam int unsigned RecipW     = 28;
  localparam int unsigned RecipShift = 27;
  localparam int unsigned TotalW     = 21;
  localparam int unsigned Pow3W      = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode     = 3'd0,
    CfgDimCount = 3'd1,
    CfgSize0    = 3'd2,
    CfgSize1    = 3'd3,
    CfgSize2    = 3'd4,
    CfgSize3    = 3'd5,
    CfgSize4    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic       ok;
    logic [2:0] pow2;
    logic       three;
  } size_dec_t;

  typedef struct packed {
    logic              active;
    logic              last;
    logic              mode;
    logic [SizeW-1:0]  size;
    logic [ShiftW-1:0] shift;
    logic [RecipW-1:0] recip;
  } lane_cfg_t;

  typedef struct packed {
    logic              err;
    logic [TotalW-1:0] total;
  } glob_cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] coord;
    logic              differ;
    logic              link;
  } lane_res_t;

  // every supported size is 2^k or 3*2^k
  function automatic size_dec_t size_decode(logic [SizeW-1:0] s, logic mode);
    size_dec_t d;
    d = '0;
    case (s)
      5'd2:  begin d.ok = 1'b1;  d.pow2 = 3'd1; end
      5'd3:  begin d.ok = !mode; d.three = 1'b1; end
      5'd4:  begin d.ok = 1'b1;  d.pow2 = 3'd2; end
      5'd6:  begin d.ok = !mode; d.pow2 = 3'd1; d.three = 1'b1; end
      5'd8:  begin d.ok = 1'b1;  d.pow2 = 3'd3; end
      5'd12: begin d.ok = !mode; d.pow2 = 3'd2; d.three = 1'b1; end
      5'd16: begin d.ok = 1'b1;  d.pow2 = 3'd4; end
      default: d = '0;
    endcase
    if (s > SizeW'(MaxDimSize)) d.ok = 1'b0;
    return d;
  endfunction

  // floor(2^27 / 3^b) + 1, exact quotient for any 20 bit dividend
  function automatic logic [RecipW-1:0] recip3(logic [ThreeW-1:0] b);
    logic [RecipW-1:0] r;
    case (b)
      3'd0:    r = 28'd134217729;
      3'd1:    r = 28'd44739243;
      3'd2:    r = 28'd14913081;
      3'd3:    r = 28'd4971027;
      3'd4:    r = 28'd1657009;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [Pow3W-1:0] pow3(logic [ThreeW-1:0] b);
    logic [Pow3W-1:0] r;
    case (b)
      3'd0:    r = 8'd1;
      3'd1:    r = 8'd3;
      3'd2:    r = 8'd9;
      3'd3:    r = 8'd27;
      3'd4:    r = 8'd81;
      3'd5:    r = 8'd243;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pta_cfg.sv]
// configuration registers and registered per-lane divisor set-up
`default_nettype none

module pta_cfg import pta_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output lane_cfg_t                lane_cfg_o [NumDims],
  output glob_cfg_t                glob_cfg_o
);

  logic              mode_q, mode_d;
  logic [CountW-1:0] dim_count_q, dim_count_d;
  logic [SizeW-1:0]  size_q [NumDims];
  logic [SizeW-1:0]  size_d [NumDims];

  lane_cfg_t         lane_cfg_d [NumDims];
  lane_cfg_t         lane_cfg_q [NumDims];
  glob_cfg_t         glob_cfg_d, glob_cfg_q;

  size_dec_t         dec [NumDims];
  logic [ShiftW-1:0] acc_shift;
  logic [ThreeW-1:0] acc_three;
  logic              size_bad;
  logic              active;

  always_comb begin
    mode_d      = mode_q;
    dim_count_d = dim_count_q;
    for (int i = 0; i < NumDims; i++) size_d[i] = size_q[i];
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMode:     mode_d      = cfg_wdata_i[0];
        CfgDimCount: dim_count_d = cfg_wdata_i[CountW-1:0];
        CfgSize0:    size_d[0]   = cfg_wdata_i;
        CfgSize1:    size_d[1]   = cfg_wdata_i;
        CfgSize2:    size_d[2]   = cfg_wdata_i;
        CfgSize3:    size_d[3]   = cfg_wdata_i;
        CfgSize4:    size_d[4]   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      dim_count_q <= CountW'(1);
      for (int i = 0; i < NumDims; i++) size_q[i] <= SizeW'(2);
    end else begin
      mode_q      <= mode_d;
      dim_count_q <= dim_count_d;
      for (int i = 0; i < NumDims; i++) size_q[i] <= size_d[i];
    end
  end

  // lane i divides by the product of the sizes below it: a shift and a power of three
  always_comb begin
    acc_shift = '0;
    acc_three = '0;
    size_bad  = 1'b0;
    active    = 1'b0;
    for (int i = 0; i < NumDims; i++) begin
      dec[i]               = size_decode(size_q[i], mode_q);
      active               = (CountW'(i) < dim_count_q);
      lane_cfg_d[i].active = active;
      lane_cfg_d[i].last   = (CountW'(i) == dim_count_q - CountW'(1));
      lane_cfg_d[i].mode   = mode_q;
      lane_cfg_d[i].size   = size_q[i];
      lane_cfg_d[i].shift  = acc_shift;
      lane_cfg_d[i].recip  = recip3(acc_three);
      if (active) begin
        acc_shift = acc_shift + ShiftW'(dec[i].pow2);
        acc_three = acc_three + ThreeW'(dec[i].three);
        if (!dec[i].ok) size_bad = 1'b1;
      end
    end
    glob_cfg_d.err   = (dim_count_q == '0) || (dim_count_q > CountW'(MaxDims)) || size_bad;
    glob_cfg_d.total = TotalW'(pow3(acc_three)) << acc_shift;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumDims; i++) lane_cfg_q[i] <= lane_cfg_d[i];
    glob_cfg_q <= glob_cfg_d;
  end

  assign lane_cfg_o = lane_cfg_q;
  assign glob_cfg_o = glob_cfg_q;

endmodule

`default_nettype wire

[rtl/core/pta_lane.sv]
// one dimension lane: prefix quotient of both nodes, then digit, difference and link
`default_nettype none

module pta_lane import pta_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_a_i,
  input  wire logic              en_b_i,
  input  wire logic [NodeW-1:0]  node_a_i,
  input  wire logic [NodeW-1:0]  node_b_i,
  input  wire lane_cfg_t         cfg_i,
  input  wire logic [CoordW-1:0] nxt_qa_i,
  input  wire logic [CoordW-1:0] nxt_qb_i,
  output logic [CoordW-1:0]      qa_lo_o,
  output logic [CoordW-1:0]      qb_lo_o,
  output lane_res_t              res_o
);

  localparam int unsigned ProdW = NodeW + RecipW;
  localparam int unsigned MulW  = SizeW + CoordW;

  logic [NodeW-1:0]  xa, xb;
  logic [ProdW-1:0]  pa, pb;
  logic [NodeW-1:0]  qa_q, qb_q;

  logic [MulW-1:0]   ma, mb;
  logic [CoordW-1:0] da, db;
  logic [SizeW-1:0]  ea, eb, sm1;
  logic              ring;
  lane_res_t         res_d, res_q;

  // stage a: floor(node / prefix product) by shift and reciprocal multiply
  assign xa = node_a_i >> cfg_i.shift;
  assign xb = node_b_i >> cfg_i.shift;
  assign pa = ProdW'(xa) * ProdW'(cfg_i.recip);
  assign pb = ProdW'(xb) * ProdW'(cfg_i.recip);

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      qa_q <= pa[RecipShift +: NodeW];
      qb_q <= pb[RecipShift +: NodeW];
    end
  end

  assign qa_lo_o = qa_q[CoordW-1:0];
  assign qb_lo_o = qb_q[CoordW-1:0];

  // stage b: digit = q_i - size_i * q_(i+1), only the low bits matter
  assign ma = MulW'(cfg_i.size) * MulW'(nxt_qa_i);
  assign mb = MulW'(cfg_i.size) * MulW'(nxt_qb_i);

  always_comb begin
    if (!cfg_i.active) begin
      da = '0;
      db = '0;
    end else if (cfg_i.last) begin
      da = qa_q[CoordW-1:0];
      db = qb_q[CoordW-1:0];
    end else begin
      da = qa_q[CoordW-1:0] - ma[CoordW-1:0];
      db = qb_q[CoordW-1:0] - mb[CoordW-1:0];
    end
    ea   = SizeW'(da);
    eb   = SizeW'(db);
    sm1  = cfg_i.size - SizeW'(1);
    ring = (ea + SizeW'(1) == eb) || (eb + SizeW'(1) == ea) ||
           (ea == '0 && eb == sm1) || (eb == '0 && ea == sm1);
    res_d.coord  = da;
    res_d.differ = cfg_i.active && (da != db);
    res_d.link   = (da != db) && (cfg_i.mode ? ring : 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/core/pta_merge.sv]
// merges lane results into the registered output transaction
`default_nettype none

module pta_merge import pta_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire lane_res_t    res_i [NumDims],
  input  wire logic         err_i,
  output logic              adjacent_o,
  output logic [CoordW-1:0] coord_o [NumDims],
  output logic [CountW-1:0] differ_count_o,
  output logic              error_o
);

  logic [CountW-1:0] cnt;
  logic              any_link;
  logic              adjacent_q;
  logic [CoordW-1:0] coord_q [NumDims];
  logic [CountW-1:0] differ_count_q;
  logic              error_q;

  always_comb begin
    cnt      = '0;
    any_link = 1'b0;
    for (int i = 0; i < NumDims; i++) begin
      cnt      = cnt + CountW'(res_i[i].differ);
      any_link = any_link | (res_i[i].differ & res_i[i].link);
    end
  end

  // an error blanks everything but the error flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adjacent_q     <= !err_i && (cnt == CountW'(1)) && any_link;
      differ_count_q <= err_i ? '0 : cnt;
      error_q        <= err_i;
      for (int i = 0; i < NumDims; i++) coord_q[i] <= err_i ? '0 : res_i[i].coord;
    end
  end

  assign adjacent_o     = adjacent_q;
  assign coord_o        = coord_q;
  assign differ_count_o = differ_count_q;
  assign error_o        = error_q;

endmodule

`default_nettype wire

[rtl/core/product_topology_adjacency_unit.sv]
// throughput: one query per cycle unless stalled; four-stage pipeline (input, quotient, digit, merge)
// stalls only back up the pipeline; bubbles are squeezed out, so an empty output register means ready
// a configuration write reaches the configuration registers, then the registered divisor set-up
// reset: topology mode 0, one dimension, all sizes 2, pipeline empty
`default_nettype none

module product_topology_adjacency_unit import pta_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [NodeW-1:0]    node_a_i,
  input  wire logic [NodeW-1:0]    node_b_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     adjacent_o,
  output logic [CoordW-1:0]        coord_0_o,
  output logic [CoordW-1:0]        coord_1_o,
  output logic [CoordW-1:0]        coord_2_o,
  output logic [CoordW-1:0]        coord_3_o,
  output logic [CoordW-1:0]        coord_4_o,
  output logic [CountW-1:0]        differ_count_o,
  output logic                     error_o
);

  lane_cfg_t         lane_cfg [NumDims];
  glob_cfg_t         glob_cfg;
  lane_res_t         lane_res [NumDims];
  logic [CoordW-1:0] qa_lo [NumDims];
  logic [CoordW-1:0] qb_lo [NumDims];
  logic [CoordW-1:0] nxt_qa [NumDims];
  logic [CoordW-1:0] nxt_qb [NumDims];
  logic [CoordW-1:0] coord [NumDims];

  logic              v1_q, v2_q, v3_q, vo_q;
  logic              en1, en2, en3, en_o;
  logic [NodeW-1:0]  na_q, nb_q;
  logic              err2_q, err3_q;

  pta_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .lane_cfg_o  (lane_cfg),
    .glob_cfg_o  (glob_cfg)
  );

  // stall chain: a stage moves when the next one is empty or moving
  assign en_o       = !vo_q || out_ready_i;
  assign en3        = !v3_q || en_o;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= in_valid_i;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      na_q <= node_a_i;
      nb_q <= node_b_i;
    end
    if (en2) begin
      err2_q <= glob_cfg.err || (TotalW'(na_q) >= glob_cfg.total) ||
                (TotalW'(nb_q) >= glob_cfg.total);
    end
    if (en3) err3_q <= err2_q;
  end

  // each lane needs the next lane's quotient to strip off the higher digits
  for (genvar g = 0; g < NumDims; g++) begin : g_lane
    if (g == NumDims - 1) begin : g_top
      assign nxt_qa[g] = '0;
      assign nxt_qb[g] = '0;
    end else begin : g_mid
      assign nxt_qa[g] = qa_lo[g+1];
      assign nxt_qb[g] = qb_lo[g+1];
    end

    pta_lane u_lane (
      .clk_i    (clk_i),
      .en_a_i   (en2),
      .en_b_i   (en3),
      .node_a_i (na_q),
      .node_b_i (nb_q),
      .cfg_i    (lane_cfg[g]),
      .nxt_qa_i (nxt_qa[g]),
      .nxt_qb_i (nxt_qb[g]),
      .qa_lo_o  (qa_lo[g]),
      .qb_lo_o  (qb_lo[g]),
      .res_o    (lane_res[g])
    );
  end

  pta_merge u_merge (
    .clk_i          (clk_i),
    .en_i           (en_o),
    .res_i          (lane_res),
    .err_i          (err3_q),
    .adjacent_o     (adjacent_o),
    .coord_o        (coord),
    .differ_count_o (differ_count_o),
    .error_o        (error_o)
  );

  assign out_valid_o = vo_q;
  assign coord_0_o   = coord[0];
  assign coord_1_o   = coord[1];
  assign coord_2_o   = coord[2];
  assign coord_3_o   = coord[3];
  assign coord_4_o   = coord[4];

  a_adj_single_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && adjacent_o |-> !error_o && differ_count_o == CountW'(1))
    else $error("adjacent reported without exactly one differing dimension");

  a_err_blanks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !adjacent_o && differ_count_o == '0 &&
      coord_0_o == '0 && coord_1_o == '0 && coord_2_o == '0 &&
      coord_3_o == '0 && coord_4_o == '0)
    else $error("error transaction carries non-zero fields");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> differ_count_o <= CountW'(MaxDims))
    else $error("differ count exceeds dimension count");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire

[verif/product_topology_adjacency_unit_tb.sv]
// self-checking testbench for the product topology adjacency unit
`default_nettype none

module product_topology_adjacency_unit_tb;
  import pta_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // the limit leaves a wide margin over the slowest correct run
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned PhaseItems  = 50;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic                           adjacent;
    logic [NumDims-1:0][CoordW-1:0] coord;
    logic [CountW-1:0]              differ_count;
    logic                           error;
  } adj_result_t;

  typedef struct packed {
    logic                          cfg_load;
    logic                          cfg_mode;
    logic [CountW-1:0]             cfg_dims;
    logic [NumDims-1:0][SizeW-1:0] cfg_sizes;
    logic [NodeW-1:0]              a;
    logic [NodeW-1:0]              b;
    logic                          known;
    adj_result_t                   res;
  } query_row_t;

  localparam adj_result_t ErrRes = adj_result_t'({1'b0, 20'h00000, 3'd0, 1'b1});
  localparam logic [NumDims-1:0][SizeW-1:0] AllTwo     = {NumDims{5'd2}};
  localparam logic [NumDims-1:0][SizeW-1:0] AllSixteen = {NumDims{5'd16}};

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgMode;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [NodeW-1:0]    node_a_i    = '0;
  logic [NodeW-1:0]    node_b_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                adjacent_o;
  logic [CoordW-1:0]   coord_0_o;
  logic [CoordW-1:0]   coord_1_o;
  logic [CoordW-1:0]   coord_2_o;
  logic [CoordW-1:0]   coord_3_o;
  logic [CoordW-1:0]   coord_4_o;
  logic [CountW-1:0]   differ_count_o;
  logic                error_o;

  product_topology_adjacency_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .adjacent_o     (adjacent_o),
    .coord_0_o      (coord_0_o),
    .coord_1_o      (coord_1_o),
    .coord_2_o      (coord_2_o),
    .coord_3_o      (coord_3_o),
    .coord_4_o      (coord_4_o),
    .differ_count_o (differ_count_o),
    .error_o        (error_o)
  );

  // shadow of the configuration registers
  logic             cur_mode = 1'b0;
  logic [CountW-1:0] cur_dims = 3'd1;
  logic [SizeW-1:0] cur_size [NumDims] = '{default: 5'd2};

  adj_result_t awaited_answers[$];
  query_row_t  directed_rows[$];
  query_row_t  next_row;

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  bit          pressure_armed  = 1'b0;
  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned unexpected_count = 0;
  int unsigned reported_count  = 0;
  int unsigned results_checked = 0;
  int unsigned adjacent_seen   = 0;
  int unsigned errored_seen    = 0;
  int unsigned settings_loaded = 0;
  int unsigned input_stall_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic adj_result_t predict_adjacency(input logic [NodeW-1:0] a,
                                                    input logic [NodeW-1:0] b);
    adj_result_t r;
    int unsigned na, nb, total, differ, diff_dim, i, s, ca, cb, link_a, link_b;
    bit bad, ok;
    r        = '0;
    na       = a;
    nb       = b;
    total    = 1;
    differ   = 0;
    diff_dim = 0;
    link_a   = 0;
    link_b   = 0;
    bad = (cur_dims == 0) || (cur_dims > MaxDims) || (cur_dims > NumDims);
    if (!bad) begin
      for (i = 0; i < cur_dims; i++) begin
        s = cur_size[i];
        case (s)
          2, 4, 8, 16: ok = 1'b1;
          3, 6, 12:    ok = !cur_mode;
          default:     ok = 1'b0;
        endcase
        if (s > MaxDimSize) ok = 1'b0;
        if (!ok) bad = 1'b1;
        else total = total * s;
      end
    end
    if (!bad && (na >= total || nb >= total)) bad = 1'b1;
    if (bad) begin
      r.error = 1'b1;
    end else begin
      for (i = 0; i < cur_dims; i++) begin
        s  = cur_size[i];
        ca = na % s;
        cb = nb % s;
        na = na / s;
        nb = nb / s;
        r.coord[i] = CoordW'(ca);
        if (ca != cb) begin
          differ++;
          diff_dim = i;
          link_a   = ca;
          link_b   = cb;
        end
      end
      r.differ_count = CountW'(differ);
      if (differ == 1) begin
        s = cur_size[diff_dim];
        if (!cur_mode) r.adjacent = 1'b1;
        else r.adjacent = (link_a + 1 == link_b) || (link_b + 1 == link_a) ||
                          (link_a == 0 && link_b == s - 1) ||
                          (link_b == 0 && link_a == s - 1);
      end
    end
    return r;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgMode:     cur_mode = data[0];
      CfgDimCount: cur_dims = data[CountW-1:0];
      default:     cur_size[idx - CfgSize0] = data;
    endcase
  endtask

  // waits for the pipeline to drain first, as every query gives exactly one answer
  task automatic program_setting(input logic [CfgDataW-1:0] mode_data,
                                 input logic [CfgDataW-1:0] dims_data,
                                 input logic [NumDims-1:0][SizeW-1:0] sizes);
    int unsigned i;
    in_valid_i <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CfgMode, mode_data);
    write_reg(CfgDimCount, dims_data);
    for (i = 0; i < NumDims; i++) write_reg(cfg_idx_e'(CfgSize0 + i), sizes[i]);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    settings_loaded++;
  endtask

  task automatic offer_query(input logic [NodeW-1:0] a, input logic [NodeW-1:0] b,
                             input bit known, input adj_result_t known_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    node_a_i   <= a;
    node_b_i   <= b;
    @(posedge clk_i);
    while (!in_ready_o) begin
      input_stall_cycles++;
      @(posedge clk_i);
    end
    awaited_answers = {awaited_answers, (known ? known_res : predict_adjacency(a, b))};
  endtask

  task automatic add_setting(input logic mode, input logic [CountW-1:0] dims,
                             input logic [NumDims-1:0][SizeW-1:0] sizes);
    next_row.cfg_load  = 1'b1;
    next_row.cfg_mode  = mode;
    next_row.cfg_dims  = dims;
    next_row.cfg_sizes = sizes;
  endtask

  task automatic add_query(input logic [NodeW-1:0] a, input logic [NodeW-1:0] b,
                           input bit known, input adj_result_t res);
    next_row.a     = a;
    next_row.b     = b;
    next_row.known = known;
    next_row.res   = res;
    directed_rows = {directed_rows, next_row};
    next_row.cfg_load = 1'b0;
  endtask

  task automatic run_phase(input int unsigned p);
    logic [NodeW-1:0]              a, b;
    logic [NumDims-1:0][SizeW-1:0] sizes;
    logic                          mode;
    logic [CountW-1:0]             dims;
    int unsigned                   dig [NumDims];
    int unsigned                   i, n, k, s, tmp, pick;
    longint unsigned               total;
    bit                            shaped;
    mode = 1'($urandom_range(1));
    if (p == 0) begin
      dims  = 3'd1;
      sizes = AllTwo;
    end else if (p == PhaseCount - 1) begin
      dims  = 3'd5;
      sizes = AllSixteen;
    end else begin
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(2))
          0:       dims = 3'd0;
          1:       dims = 3'd6;
          default: dims = 3'd7;
        endcase
      end else begin
        dims = CountW'($urandom_range(1, 5));
      end
      for (i = 0; i < NumDims; i++) begin
        if ($urandom_range(99) < 8) sizes[i] = SizeW'($urandom_range(31));
        else if (mode) sizes[i] = SizeW'(2 << $urandom_range(3));
        else begin
          case ($urandom_range(6))
            0:       sizes[i] = 5'd2;
            1:       sizes[i] = 5'd3;
            2:       sizes[i] = 5'd4;
            3:       sizes[i] = 5'd6;
            4:       sizes[i] = 5'd8;
            5:       sizes[i] = 5'd12;
            default: sizes[i] = 5'd16;
          endcase
        end
      end
    end
    // upper data bits are don't-care for the narrow registers
    program_setting({4'($urandom_range(15)), mode}, {2'($urandom_range(3)), dims}, sizes);
    case (p % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
    if (p == 4) pressure_armed = 1'b1;

    shaped = (cur_dims >= 1) && (cur_dims <= NumDims);
    total  = 1;
    if (shaped) begin
      for (i = 0; i < cur_dims; i++) begin
        if (cur_size[i] < 2) shaped = 1'b0;
        else total = total * cur_size[i];
      end
    end
    if (total > (64'd1 << NodeW)) shaped = 1'b0;

    for (n = 0; n < PhaseItems; n++) begin
      if (!shaped) begin
        a = NodeW'($urandom);
        b = $urandom_range(1) ? a : NodeW'($urandom);
      end else begin
        a    = NodeW'($urandom_range(32'(total - 1)));
        pick = $urandom_range(99);
        if (pick < 50) begin
          // move one coordinate, ring steps half the time in mode 1
          tmp = a;
          for (i = 0; i < cur_dims; i++) begin
            dig[i] = tmp % cur_size[i];
            tmp    = tmp / cur_size[i];
          end
          k = $urandom_range(cur_dims - 1);
          s = cur_size[k];
          if (cur_mode && $urandom_range(1))
            dig[k] = $urandom_range(1) ? (dig[k] + 1) % s : (dig[k] + s - 1) % s;
          else
            dig[k] = (dig[k] + 1 + $urandom_range(s - 2)) % s;
          tmp = 0;
          for (i = cur_dims; i > 0; i--) tmp = tmp * cur_size[i-1] + dig[i-1];
          b = NodeW'(tmp);
        end else if (pick < 65) begin
          b = a;
        end else if (pick < 88) begin
          b = NodeW'($urandom_range(32'(total - 1)));
        end else begin
          b = NodeW'($urandom);
          if ($urandom_range(1)) begin
            a = b;
            b = NodeW'($urandom_range(32'(total - 1)));
          end
        end
      end
      offer_query(a, b, 1'b0, ErrRes);
    end
  endtask

  // answer checker and receiver back-pressure
  initial begin
    adj_result_t got, want;
    int unsigned hold_left;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = adj_result_t'({adjacent_o, coord_4_o, coord_3_o, coord_2_o, coord_1_o,
                             coord_0_o, differ_count_o, error_o});
        if (awaited_answers.size() == 0) begin
          unexpected_count++;
          if (reported_count < ReportLimit)
            $display("unexpected answer: adj=%0b coords=%h differ=%0d err=%0b",
                     got.adjacent, got.coord, got.differ_count, got.error);
          reported_count++;
        end else begin
          want = awaited_answers[0];
          awaited_answers.delete(0);
          if (got.adjacent !== want.adjacent || got.coord !== want.coord ||
              got.differ_count !== want.differ_count || got.error !== want.error) begin
            mismatch_count++;
            if (reported_count < ReportLimit) begin
              $display("mismatch on answer %0d: expected adj=%0b coords=%h differ=%0d err=%0b",
                       results_checked, want.adjacent, want.coord, want.differ_count,
                       want.error);
              $display("  got adj=%0b coords=%h differ=%0d err=%0b",
                       got.adjacent, got.coord, got.differ_count, got.error);
            end
            reported_count++;
          end
          results_checked++;
          if (want.adjacent) adjacent_seen++;
          if (want.error) errored_seen++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (pressure_armed && !pressure_done) begin
        hold_left     = HoldCycles - 1;
        pressure_done = 1'b1;
        out_ready_i   <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d answers still awaited",
             cycle_count, awaited_answers.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    query_row_t  row;
    int unsigned n;
    next_row = '0;

    // reset values: one dimension of size 2, complete graph
    add_query(20'h00000, 20'h00001, 1'b1, adj_result_t'({1'b1, 20'h00000, 3'd1, 1'b0}));
    add_query(20'h00001, 20'h00001, 1'b1, adj_result_t'({1'b0, 20'h00001, 3'd0, 1'b0}));
    add_query(20'h00002, 20'h00000, 1'b1, ErrRes);
    add_query(20'h00000, 20'h00002, 1'b1, ErrRes);
    add_query(20'hFFFFF, 20'hFFFFF, 1'b1, ErrRes);
    // full 20 bit node space, complete graphs
    add_setting(1'b0, 3'd5, AllSixteen);
    add_query(20'hFFFFF, 20'hFFFFF, 1'b1, adj_result_t'({1'b0, 20'hFFFFF, 3'd0, 1'b0}));
    add_query(20'h00000, 20'hFFFFF, 1'b1, adj_result_t'({1'b0, 20'h00000, 3'd5, 1'b0}));
    add_query(20'h00000, 20'hF0000, 1'b1, adj_result_t'({1'b1, 20'h00000, 3'd1, 1'b0}));
    add_query(20'h12345, 20'h12385, 1'b0, ErrRes);
    // rings, including the wrap from 0 to size-1
    add_setting(1'b1, 3'd5, AllSixteen);
    add_query(20'h00000, 20'h0000F, 1'b1, adj_result_t'({1'b1, 20'h00000, 3'd1, 1'b0}));
    add_query(20'h00000, 20'h00002, 1'b1, adj_result_t'({1'b0, 20'h00000, 3'd1, 1'b0}));
    add_query(20'h00003, 20'h00004, 1'b0, ErrRes);
    add_query(20'hFFFFF, 20'hFFFFE, 1'b0, ErrRes);
    // size 3 is not a ring size
    add_setting(1'b1, 3'd1, {5'd2, 5'd2, 5'd2, 5'd2, 5'd3});
    add_query(20'h00000, 20'h00000, 1'b1, ErrRes);
    // bad dimension counts
    add_setting(1'b0, 3'd0, AllTwo);
    add_query(20'h00000, 20'h00000, 1'b1, ErrRes);
    add_setting(1'b0, 3'd6, AllTwo);
    add_query(20'h00000, 20'h00001, 1'b1, ErrRes);
    add_setting(1'b0, 3'd7, AllTwo);
    add_query(20'h00000, 20'h00000, 1'b1, ErrRes);
    // mixed radix 3 x 6 x 12, top node and first node past the end
    add_setting(1'b0, 3'd3, {5'd2, 5'd2, 5'd12, 5'd6, 5'd3});
    add_query(20'd215, 20'd215, 1'b0, ErrRes);
    add_query(20'd215, 20'd216, 1'b1, ErrRes);
    add_query(20'd0, 20'd1, 1'b0, ErrRes);
    // sizes above the maximum, zero, and a complete-only size in ring mode
    add_setting(1'b0, 3'd1, {5'd2, 5'd2, 5'd2, 5'd2, 5'd17});
    add_query(20'h00000, 20'h00001, 1'b1, ErrRes);
    add_setting(1'b0, 3'd2, {5'd2, 5'd2, 5'd2, 5'd0, 5'd2});
    add_query(20'h00000, 20'h00000, 1'b1, ErrRes);
    add_setting(1'b1, 3'd2, {5'd2, 5'd2, 5'd2, 5'd12, 5'd4});
    add_query(20'h00000, 20'h00000, 1'b1, ErrRes);
    // smallest ring
    add_setting(1'b1, 3'd2, AllTwo);
    add_query(20'h00000, 20'h00001, 1'b0, ErrRes);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < directed_rows.size(); n++) begin
      row = directed_rows[n];
      if (row.cfg_load)
        program_setting({4'b0, row.cfg_mode}, {2'b0, row.cfg_dims}, row.cfg_sizes);
      offer_query(row.a, row.b, row.known, row.res);
    end

    for (n = 0; n < PhaseCount; n++) run_phase(n);

    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d answers checked over %0d register settings: %0d adjacent, %0d with error",
             results_checked, settings_loaded, adjacent_seen, errored_seen);
    $display("idle phases on sender, receiver and both; %0d cycles of input back-pressure",
             input_stall_cycles);
    if (mismatch_count == 0 && unexpected_count == 0 && awaited_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d unexpected answers", mismatch_count, unexpected_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
